FILE: rtl/csa_pkg.sv
// Package for the contiguous segment allocator: sizes, codes, entry layout
// and the structs passed between the controller, RAM and top level. No deps.
`timescale 1ns / 1ps

package csa_pkg;

   localparam int MEM_UNITS  = 256;
   localparam int OWNER_BITS = 8;

   localparam int IDX_W      = $clog2(MEM_UNITS);
   localparam int CNT_W      = $clog2(MEM_UNITS + 1);
   localparam int SIZE_W     = CNT_W;

   // fixed port field widths
   localparam int OPC_W      = 1;
   localparam int ID_W       = 8;
   localparam int REQ_SIZE_W = 9;
   localparam int START_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int FIT_W      = 2;
   localparam int CMP_W      = (SIZE_W > REQ_SIZE_W) ? SIZE_W : REQ_SIZE_W;

   typedef enum logic [OPC_W-1:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [FIT_W-1:0] {
      FIT_FIRST = 2'd0,
      FIT_NEXT  = 2'd1,
      FIT_BEST  = 2'd2,
      FIT_WORST = 2'd3
   } fit_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_HOLE  = 2'd1,
      ST_NO_OWNER = 2'd2,
      ST_ZERO     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_WR_NEW,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0]      start;
      logic [SIZE_W-1:0]     size;
      logic                  used;
      logic [OWNER_BITS-1:0] owner;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      opcode_type            opcode;
      logic [OWNER_BITS-1:0] owner;
      logic [REQ_SIZE_W-1:0] size;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [START_W-1:0]   start;
   } res_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

endpackage

FILE: rtl/csa_if.sv
// Channel interfaces of the segment allocator: request, response, csr write.
// Depends on csa_pkg.
`timescale 1ns / 1ps

interface csa_req_if;
   import csa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OPC_W-1:0]      opcode;
   logic [ID_W-1:0]       owner_id;
   logic [REQ_SIZE_W-1:0] request_size;
   modport source (output valid, opcode, owner_id, request_size, input ready);
   modport sink   (input valid, opcode, owner_id, request_size, output ready);
endinterface

interface csa_rsp_if;
   import csa_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status_code;
   logic [START_W-1:0]  segment_start;
   modport source (output valid, status_code, segment_start, input ready);
   modport sink   (input valid, status_code, segment_start, output ready);
endinterface

interface csa_csr_if;
   import csa_pkg::*;
   logic             valid;
   logic             ready;
   logic [FIT_W-1:0] fit_strategy;
   modport source (output valid, fit_strategy, input ready);
   modport sink   (input valid, fit_strategy, output ready);
endinterface

FILE: rtl/contiguous_segment_allocator_core.sv
// Top level of the contiguous segment allocator: csr register, response
// register, segment table RAM and sequencer. Depends on csa_pkg, csa_if,
// csa_ram and csa_ctrl.
//
// Usage:
//  - req_chan carries one item per request: opcode (allocate / free),
//    owner_id and request_size. csr_chan writes fit_strategy, only while the
//    block is idle (a rule for the user, not enforced); it is always ready.
//  - rsp_chan returns one item per request: status_code and segment_start.
//  - Sequence: an item walks the whole segment table (count reads, one per
//    cycle through the RAM's single read port), takes a decision step,
//    then shifts the entries behind the chosen one on a split or merge,
//    and on a split writes the split-off remainder. Zero-size requests
//    skip the table and go straight to the result.
//  - One item is in work at a time; req_ready is high only while idle.
//  - Reset: synchronous, active high. After reset the block writes the
//    initial free segment to table entry 0 and then accepts items.
//  - Stall: a finished result sits in the response register; the next item
//    is accepted meanwhile and its result waits in the sequencer until the
//    register is taken.
`timescale 1ns / 1ps

module contiguous_segment_allocator_core (
   input  logic      clock,
   input  logic      reset,
   csa_req_if.sink   req_chan,
   csa_rsp_if.source rsp_chan,
   csa_csr_if.sink   csr_chan
);
   import csa_pkg::*;

   fit_type     strat_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   res_type     rsp_data_ff;
   req_type     req_data;
   res_type     res_data;
   logic        res_valid;
   logic        res_ready;
   mem_req_type mem_req;
   entry_type   mem_rdata;
   logic [ENTRY_W-1:0] rdata_raw;

   // strategy register, written whenever the csr channel presents a value
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strat_ff <= FIT_FIRST;
      end else if (csr_chan.valid) begin
         strat_ff <= fit_type'(csr_chan.fit_strategy);
      end
   end

   // owner id is cut or widened to the stored owner width
   assign req_data = '{opcode: opcode_type'(req_chan.opcode),
                       owner:  OWNER_BITS'(req_chan.owner_id),
                       size:   req_chan.request_size};

   // response register: loads when empty or being drained
   assign res_ready    = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = (res_valid && res_ready) ? 1'b1 :
                         (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status_code   = rsp_data_ff.status;
   assign rsp_chan.segment_start = rsp_data_ff.start;

   csa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_data  (req_data),
      .strategy  (strat_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   // segment table, one entry per segment in address order
   csa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MEM_UNITS)
   ) u_table (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (rdata_raw)
   );

   assign mem_rdata = entry_type'(rdata_raw);

   // a result is loaded only into a free or draining response register
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("response register overwritten while stalled");

   // no item is taken while the sequencer still holds a result
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_chan.ready)
      else $error("request accepted with result pending");

   // csr writes land in the strategy register
   assert property (@(posedge clock) disable iff (reset)
      csr_chan.valid |=> strat_ff == $past(csr_chan.fit_strategy))
      else $error("strategy write lost");

endmodule

FILE: rtl/csa_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module csa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/csa_ctrl.sv
// Sequencer of the segment allocator: table scan, decision, entry shifting.
// Depends on csa_pkg; drives the segment table RAM through mem_req.
`timescale 1ns / 1ps

module csa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  csa_pkg::req_type      req_data,
   input  csa_pkg::fit_type      strategy,
   output logic                  res_valid,
   input  logic                  res_ready,
   output csa_pkg::res_type      res_data,
   output csa_pkg::mem_req_type  mem_req,
   input  csa_pkg::entry_type    mem_rdata
);
   import csa_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      nfp_ff, nfp_in;
   opcode_type            op_ff, op_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic [CMP_W-1:0]      size_ff, size_in;
   logic [CNT_W-1:0]      base_ff, base_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pick_idx_ff, pick_idx_in;
   entry_type             pick_e_ff, pick_e_in;
   entry_type             prev_e_ff, prev_e_in;
   entry_type             last_e_ff, last_e_in;
   entry_type             next_e_ff, next_e_in;
   logic                  want_next_ff, want_next_in;
   logic                  has_next_ff, has_next_in;
   entry_type             new_e_ff, new_e_in;
   logic [IDX_W-1:0]      new_idx_ff, new_idx_in;
   logic [CNT_W-1:0]      sh_rd_ff, sh_rd_in;
   logic [CNT_W-1:0]      sh_left_ff, sh_left_in;
   logic                  sh_up_ff, sh_up_in;
   logic [1:0]            sh_dist_ff, sh_dist_in;
   res_type               res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         count_ff  <= CNT_W'(1);
         nfp_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         nfp_ff    <= nfp_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      owner_ff     <= owner_in;
      size_ff      <= size_in;
      base_ff      <= base_in;
      k_ff         <= k_in;
      rd_idx_ff    <= rd_idx_in;
      found_ff     <= found_in;
      pick_idx_ff  <= pick_idx_in;
      pick_e_ff    <= pick_e_in;
      prev_e_ff    <= prev_e_in;
      last_e_ff    <= last_e_in;
      next_e_ff    <= next_e_in;
      want_next_ff <= want_next_in;
      has_next_ff  <= has_next_in;
      new_e_ff     <= new_e_in;
      new_idx_ff   <= new_idx_in;
      sh_rd_ff     <= sh_rd_in;
      sh_left_ff   <= sh_left_in;
      sh_up_ff     <= sh_up_in;
      sh_dist_ff   <= sh_dist_in;
      res_ff       <= res_in;
   end

   always_comb begin
      logic [CNT_W:0]    scan_sum;
      logic              fit;
      logic              take;
      entry_type         e;
      logic [CNT_W-1:0]  i_c;
      logic [CNT_W-1:0]  p1;
      logic [CNT_W-1:0]  n;
      logic [CNT_W-1:0]  c2;
      logic [CNT_W-1:0]  src;
      logic [CNT_W-1:0]  newc;
      logic [SIZE_W-1:0] rest;
      logic [SIZE_W-1:0] msize;
      logic              mr;
      logic              ml;
      logic [1:0]        d;

      state_in     = state_ff;
      count_in     = count_ff;
      nfp_in       = nfp_ff;
      op_in        = op_ff;
      owner_in     = owner_ff;
      size_in      = size_ff;
      base_in      = base_ff;
      k_in         = k_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      pick_idx_in  = pick_idx_ff;
      pick_e_in    = pick_e_ff;
      prev_e_in    = prev_e_ff;
      last_e_in    = last_e_ff;
      next_e_in    = next_e_ff;
      want_next_in = want_next_ff;
      has_next_in  = has_next_ff;
      new_e_in     = new_e_ff;
      new_idx_in   = new_idx_ff;
      sh_rd_in     = sh_rd_ff;
      sh_left_in   = sh_left_ff;
      sh_up_in     = sh_up_ff;
      sh_dist_in   = sh_dist_ff;
      res_in       = res_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      mem_req      = '0;
      e            = mem_rdata;
      scan_sum     = '0;
      fit          = 1'b0;
      take         = 1'b0;
      i_c          = CNT_W'(pick_idx_ff);
      p1           = i_c + CNT_W'(1);
      n            = CNT_W'(nfp_ff);
      c2           = count_ff;
      src          = '0;
      newc         = count_ff;
      rest         = '0;
      msize        = '0;
      mr           = 1'b0;
      ml           = 1'b0;
      d            = 2'd0;

      unique case (state_ff)
         S_INIT: begin
            // table starts as one free segment over all of memory
            mem_req.we          = 1'b1;
            mem_req.waddr       = '0;
            mem_req.wdata       = '0;
            mem_req.wdata.size  = SIZE_W'(MEM_UNITS);
            state_in            = S_IDLE;
         end

         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in        = req_data.opcode;
               owner_in     = req_data.owner;
               size_in      = CMP_W'(req_data.size);
               base_in      = (req_data.opcode == OP_ALLOC && strategy == FIT_NEXT) ?
                              CNT_W'(nfp_ff) : '0;
               k_in         = '0;
               found_in     = 1'b0;
               want_next_in = 1'b0;
               has_next_in  = 1'b0;
               if (req_data.opcode == OP_ALLOC && req_data.size == '0) begin
                  res_in   = '{status: ST_ZERO, start: '0};
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (k_ff < count_ff) begin
               scan_sum = {1'b0, base_ff} + {1'b0, k_ff};
               if (scan_sum >= {1'b0, count_ff}) begin
                  scan_sum = scan_sum - {1'b0, count_ff};
               end
               mem_req.raddr = IDX_W'(scan_sum);
               rd_vld_in     = 1'b1;
               rd_idx_in     = IDX_W'(scan_sum);
               k_in          = k_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = S_DECIDE;
            end
            if (rd_vld_ff) begin
               if (op_ff == OP_FREE) begin
                  if (!found_ff && e.used && e.owner == owner_ff) begin
                     found_in     = 1'b1;
                     pick_idx_in  = rd_idx_ff;
                     pick_e_in    = e;
                     prev_e_in    = last_e_ff;
                     want_next_in = 1'b1;
                  end else if (want_next_ff) begin
                     next_e_in    = e;
                     has_next_in  = 1'b1;
                     want_next_in = 1'b0;
                  end
               end else begin
                  fit  = !e.used && (CMP_W'(e.size) >= size_ff);
                  take = fit && (!found_ff ||
                         (strategy == FIT_BEST  && e.size < pick_e_ff.size) ||
                         (strategy == FIT_WORST && e.size > pick_e_ff.size));
                  if (take) begin
                     found_in    = 1'b1;
                     pick_idx_in = rd_idx_ff;
                     pick_e_in   = e;
                  end
               end
               last_e_in = e;
            end
         end

         S_DECIDE: begin
            if (!found_ff) begin
               res_in   = '{status: (op_ff == OP_FREE) ? ST_NO_OWNER : ST_NO_HOLE,
                            start: '0};
               state_in = S_RESP;
            end else if (op_ff == OP_ALLOC) begin
               rest          = pick_e_ff.size - SIZE_W'(size_ff);
               mem_req.we    = 1'b1;
               mem_req.waddr = pick_idx_ff;
               mem_req.wdata = '{start: pick_e_ff.start, size: SIZE_W'(size_ff),
                                 used: 1'b1, owner: owner_ff};
               newc = count_ff + ((rest != '0) ? CNT_W'(1) : CNT_W'(0));
               if (rest != '0 && n >= p1) begin
                  n = n + CNT_W'(1);
               end
               if (strategy == FIT_NEXT) begin
                  n = (p1 < newc) ? p1 : '0;
               end
               nfp_in     = IDX_W'(n);
               count_in   = newc;
               new_e_in   = '{start: pick_e_ff.start + IDX_W'(size_ff), size: rest,
                              used: 1'b0, owner: '0};
               new_idx_in = IDX_W'(p1);
               sh_up_in   = 1'b1;
               sh_dist_in = 2'd1;
               sh_rd_in   = count_ff - CNT_W'(1);
               sh_left_in = count_ff - p1;
               res_in     = '{status: ST_OK, start: START_W'(pick_e_ff.start)};
               if (rest == '0) begin
                  state_in = S_RESP;
               end else if (count_ff != p1) begin
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_WR_NEW;
               end
            end else begin
               mr    = has_next_ff && !next_e_ff.used;
               ml    = (pick_idx_ff != '0) && !prev_e_ff.used;
               d     = {1'b0, mr} + {1'b0, ml};
               msize = pick_e_ff.size + (mr ? next_e_ff.size : '0) +
                       (ml ? prev_e_ff.size : '0);
               mem_req.we    = 1'b1;
               mem_req.waddr = ml ? (pick_idx_ff - IDX_W'(1)) : pick_idx_ff;
               mem_req.wdata = '{start: ml ? prev_e_ff.start : pick_e_ff.start,
                                 size: msize, used: 1'b0, owner: '0};
               // pointer follows the same deletions as the table, right one first
               if (mr) begin
                  if (n > p1) begin
                     n = n - CNT_W'(1);
                  end else if (n == p1 && p1 >= count_ff - CNT_W'(1)) begin
                     n = '0;
                  end
                  c2 = count_ff - CNT_W'(1);
               end
               if (ml) begin
                  if (n > i_c) begin
                     n = n - CNT_W'(1);
                  end else if (n == i_c && i_c >= c2 - CNT_W'(1)) begin
                     n = '0;
                  end
               end
               nfp_in     = IDX_W'(n);
               count_in   = count_ff - CNT_W'(d);
               src        = p1 + CNT_W'(mr);
               sh_up_in   = 1'b0;
               sh_dist_in = d;
               sh_rd_in   = src;
               sh_left_in = (d != 2'd0) ? (count_ff - src) : '0;
               res_in     = '{status: ST_OK, start: START_W'(pick_e_ff.start)};
               state_in   = (d != 2'd0 && count_ff != src) ? S_SHIFT : S_RESP;
            end
         end

         S_SHIFT: begin
            if (sh_left_ff != '0) begin
               mem_req.raddr = IDX_W'(sh_rd_ff);
               rd_vld_in     = 1'b1;
               rd_idx_in     = IDX_W'(sh_rd_ff);
               sh_rd_in      = sh_up_ff ? (sh_rd_ff - CNT_W'(1)) : (sh_rd_ff + CNT_W'(1));
               sh_left_in    = sh_left_ff - CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = (op_ff == OP_ALLOC) ? S_WR_NEW : S_RESP;
            end
            if (rd_vld_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = sh_up_ff ? (rd_idx_ff + IDX_W'(1))
                                        : (rd_idx_ff - IDX_W'(sh_dist_ff));
               mem_req.wdata = mem_rdata;
            end
         end

         S_WR_NEW: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = new_idx_ff;
            mem_req.wdata = new_e_ff;
            state_in      = S_RESP;
         end

         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res_data = res_ff;

   // table never empty, never more segments than units
   assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CNT_W'(MEM_UNITS))
      else $error("segment count out of range");

   // next-fit pointer always names a live segment between requests
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> CNT_W'(nfp_ff) < count_ff)
      else $error("next-fit pointer past table end");

   // no read left in flight once a request is finished
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !rd_vld_ff)
      else $error("stray table read in idle");

   // errors report address zero
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ff.status != ST_OK |-> res_ff.start == '0)
      else $error("nonzero start on error result");

endmodule

FILE: bench/tb_contiguous_segment_allocator_core.sv
// Self-checking bench for the contiguous segment allocator core: drives
// allocate/free items under all fit strategies. Depends on csa_pkg, csa_if.
`timescale 1ns / 1ps

module tb_contiguous_segment_allocator_core;
   import csa_pkg::*;

   // One expected response from the allocator model.
   typedef struct {
      status_type          status;
      logic [START_W-1:0]  start;
   } alloc_answer_type;

   // Allocator model plus the queue of answers still owed by the block.
   class alloc_scoreboard;
      int unsigned seg_base[MEM_UNITS];
      int unsigned seg_len[MEM_UNITS];
      bit          seg_busy[MEM_UNITS];
      int unsigned seg_who[MEM_UNITS];
      int unsigned nseg;
      int unsigned resume_at;
      fit_type     strategy;
      alloc_answer_type owed[$];
      int          errors;

      function void clear();
         foreach (seg_len[k]) begin
            seg_base[k] = 0; seg_len[k] = 0; seg_busy[k] = 0; seg_who[k] = 0;
         end
         seg_len[0] = MEM_UNITS;
         nseg = 1;
         resume_at = 0;
         strategy = FIT_FIRST;
         owed.delete();
      endfunction

      function void split_after(int unsigned at, int unsigned base, int unsigned len);
         if (nseg >= MEM_UNITS || at > nseg) return;
         for (int unsigned k = nseg; k > at; k--) begin
            seg_base[k] = seg_base[k-1]; seg_len[k] = seg_len[k-1];
            seg_busy[k] = seg_busy[k-1]; seg_who[k] = seg_who[k-1];
         end
         seg_base[at] = base; seg_len[at] = len; seg_busy[at] = 0; seg_who[at] = 0;
         nseg++;
         if (resume_at >= at) resume_at++;
      endfunction

      function void drop_seg(int unsigned at);
         if (at >= nseg) return;
         for (int unsigned k = at; k + 1 < nseg; k++) begin
            seg_base[k] = seg_base[k+1]; seg_len[k] = seg_len[k+1];
            seg_busy[k] = seg_busy[k+1]; seg_who[k] = seg_who[k+1];
         end
         nseg--;
         if (resume_at > at) resume_at--;
         else if (resume_at == at && at >= nseg) resume_at = 0;
      endfunction

      function bit hole_fits(int unsigned k, int unsigned len);
         return !seg_busy[k] && seg_len[k] >= len;
      endfunction

      // Note an accepted request and queue its expected answer.
      function void note_request(opcode_type op, logic [7:0] who, logic [8:0] len);
         alloc_answer_type a;
         int unsigned pick, k, idx;
         bit found;
         a.status = ST_OK; a.start = 0; found = 0; pick = 0;
         if (op == OP_ALLOC) begin
            if (len == 0) a.status = ST_ZERO;
            else begin
               if (strategy == FIT_NEXT) begin
                  if (resume_at >= nseg) resume_at = 0;
                  for (k = 0; k < nseg && !found; k++) begin
                     idx = (resume_at + k) % nseg;
                     if (hole_fits(idx, len)) begin pick = idx; found = 1; end
                  end
               end else begin
                  for (k = 0; k < nseg; k++) begin
                     if (!hole_fits(k, len)) continue;
                     if (!found || (strategy == FIT_BEST && seg_len[k] < seg_len[pick]) ||
                         (strategy == FIT_WORST && seg_len[k] > seg_len[pick])) begin
                        if (!found || strategy != FIT_FIRST) pick = k;
                        found = 1;
                     end
                  end
               end
               if (!found) a.status = ST_NO_HOLE;
               else begin
                  int unsigned rest;
                  a.start = seg_base[pick][7:0];
                  rest = seg_len[pick] - len;
                  seg_busy[pick] = 1; seg_len[pick] = len; seg_who[pick] = who;
                  if (rest > 0) split_after(pick + 1, seg_base[pick] + len, rest);
                  if (strategy == FIT_NEXT) resume_at = (pick + 1 < nseg) ? pick + 1 : 0;
               end
            end
         end else begin
            for (k = 0; k < nseg; k++)
               if (seg_busy[k] && seg_who[k] == who) begin found = 1; break; end
            if (!found) a.status = ST_NO_OWNER;
            else begin
               a.start = seg_base[k][7:0];
               seg_busy[k] = 0; seg_who[k] = 0;
               if (k + 1 < nseg && !seg_busy[k+1]) begin
                  seg_len[k] += seg_len[k+1]; drop_seg(k + 1);
               end
               if (k > 0 && !seg_busy[k-1]) begin
                  seg_len[k-1] += seg_len[k]; drop_seg(k);
               end
            end
         end
         owed.push_back(a);
      endfunction

      function void check_response(logic [1:0] st, logic [7:0] start);
         alloc_answer_type a;
         if (owed.size() == 0) begin
            $display("%0t: unexpected response status=%0d start=%0d", $time, st, start);
            errors++;
            return;
         end
         a = owed.pop_front();
         if (st !== a.status) begin
            $display("%0t: status expected %0d actual %0d", $time, a.status, st);
            errors++;
         end
         if (start !== a.start) begin
            $display("%0t: segment_start expected %0d actual %0d", $time, a.start, start);
            errors++;
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int DRAIN_CYCLES = 600;

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   csa_req_if req_chan();
   csa_rsp_if rsp_chan();
   csa_csr_if csr_chan();

   contiguous_segment_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   alloc_scoreboard board;
   int send_idle_pct = 0;   // chance per cycle that the sender holds back
   int recv_idle_pct = 0;   // chance per cycle that the receiver stalls
   int hold_rsp      = 0;   // long receiver hold-off, in cycles
   int unsigned cycles = 0;

   initial begin
      board = new();
      board.clear();
      board.errors = 0;
      req_chan.valid = 0; req_chan.opcode = 0; req_chan.owner_id = 0;
      req_chan.request_size = 0;
      csr_chan.valid = 0; csr_chan.fit_strategy = 0;
      rsp_chan.ready = 0;
   end

   // Receiver: random stalls plus an optional long hold-off.
   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready && !reset)
         board.check_response(rsp_chan.status_code, rsp_chan.segment_start);
      if (hold_rsp > 0) begin
         hold_rsp <= hold_rsp - 1;
         rsp_chan.ready <= 0;
      end else
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_contiguous_segment_allocator_core: done, errors");
         $finish;
      end
   end

   // Offer one item and wait until it is taken; the model is updated at acceptance.
   // valid stays high after acceptance so back-to-back items need no gap.
   task automatic send_item(opcode_type op, logic [7:0] who, logic [8:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.opcode <= op;
      req_chan.owner_id <= who;
      req_chan.request_size <= len;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(op, who, len);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Strategy changes only while idle.
   task automatic set_strategy(fit_type f);
      wait_drained();
      csr_chan.valid <= 1;
      csr_chan.fit_strategy <= f;
      do @(posedge clock); while (!csr_chan.ready);
      board.strategy = f;
      csr_chan.valid <= 0;
   endtask

   // Random item mix: mostly small allocations and frees of live owners.
   task automatic random_item();
      int r;
      logic [7:0] who;
      logic [8:0] len;
      r = $urandom_range(99);
      who = (r < 85) ? 8'($urandom_range(15)) : 8'($urandom);
      if (r < 50) begin
         len = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 24));
         send_item(OP_ALLOC, who, len);
      end else if (r < 55)
         send_item(OP_ALLOC, who, 9'($urandom_range(0, 1) ? 0 : 256));
      else
         send_item(OP_FREE, who, 9'($urandom));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: edge sizes, owner extremes, all error codes.
      send_item(OP_ALLOC, 8'd0, 9'd0);          // zero size
      send_item(OP_ALLOC, 8'd1, 9'd257);        // larger than memory
      send_item(OP_ALLOC, 8'd1, 9'd511);
      send_item(OP_FREE, 8'd9, 9'd0);           // owner not found
      send_item(OP_ALLOC, 8'd255, 9'd256);      // whole memory
      send_item(OP_ALLOC, 8'd2, 9'd1);          // nothing left
      send_item(OP_FREE, 8'd255, 9'h1FF);
      send_item(OP_ALLOC, 8'd3, 9'd10);
      send_item(OP_ALLOC, 8'd3, 9'd20);         // same owner twice
      send_item(OP_ALLOC, 8'd4, 9'd5);
      send_item(OP_FREE, 8'd3, 9'd0);           // lowest-address one goes
      send_item(OP_ALLOC, 8'd170, 9'd3);
      send_item(OP_ALLOC, 8'd85, 9'd200);
      send_item(OP_FREE, 8'd4, 9'd0);           // neighbours both in use, no merge
      send_item(OP_FREE, 8'd3, 9'd0);
      // Tie handling and next-fit wrap under each strategy.
      for (int f = 3; f >= 0; f--) begin
         set_strategy(fit_type'(f));
         send_item(OP_ALLOC, 8'd7, 9'd2);
         send_item(OP_ALLOC, 8'd7, 9'd1);
      end

      // Random phases: sweep strategies across idling patterns.
      for (int ph = 0; ph < 12; ph++) begin
         set_strategy(fit_type'(ph % 4));
         send_idle_pct = (ph < 4) ? 29 : (ph < 8) ? 87 : 0;
         recv_idle_pct = (ph < 4) ? 87 : (ph < 8) ? 29 : 0;
         if (ph == 9) hold_rsp = 3000;   // block fills up and stalls its input
         for (int n = 0; n < 100; n++) random_item();
         if (ph == 5) wait_drained();    // sender pause until all answered
      end

      wait_drained();
      if (board.errors == 0 && board.owed.size() == 0)
         $display("tb_contiguous_segment_allocator_core: done, clean");
      else
         $display("tb_contiguous_segment_allocator_core: done, errors");
      $finish;
   end
endmodule
